@@ hw/rtl/kr_pkg.sv @@
// Shared types and constants for the keyed record table.
// Holds the request and result structs, codes, cell control and state types.
// No dependencies.
`timescale 1ns / 1ps

package kr_pkg;

    // Action codes carried in a request.
    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_LOOKUP = 3'd1,
        ACT_UPDATE = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_LIST   = 3'd4
    } action_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUP       = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_CANCEL    = 3'd4,
        ST_INVALID   = 3'd5,
        ST_EMPTY     = 3'd6
    } status_t;

    // Update target codes; the remaining codes are invalid targets.
    typedef enum logic [2:0] {
        ED_CANCEL   = 3'd0,
        ED_TITLE    = 3'd1,
        ED_ARTIST   = 3'd2,
        ED_DURATION = 3'd3,
        ED_GENRE    = 3'd4
    } edit_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_FIND,
        S_ACT,
        S_LIST
    } state_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_LOAD,
        CELL_EDIT,
        CELL_SHIFT
    } cell_op_t;

    // Command from the controller to the chain.
    typedef struct packed {
        cell_op_t   op;
        logic [2:0] edit;
    } kr_cmd_t;

    // Per-cell control: the broadcast command plus the cell's position flags.
    typedef struct packed {
        cell_op_t   op;
        logic [2:0] edit;
        logic       sel;    // this cell is the target entry
        logic       above;  // this cell sits at or after the target entry
        logic       live;   // this cell holds an entry below the fill count
    } kr_cell_ctl_t;

    // One request.
    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] key;
        logic [15:0] duration_in;
        logic [63:0] title_in;
        logic [63:0] artist_in;
        logic [63:0] genre_in;
        logic [2:0]  edit_field;
    } kr_req_t;

    // One result.
    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [15:0] key_out;
        logic [15:0] duration_out;
        logic [10:0] minutes_out;
        logic [5:0]  seconds_out;
        logic [63:0] title_out;
        logic [63:0] artist_out;
        logic [63:0] genre_out;
        logic [5:0]  fill_count;
        logic        last;
    } kr_res_t;

    // Minutes are taken as (duration * RECIP_MUL) >> RECIP_SHIFT, exact for 16 bits.
    localparam int          SEC_PER_MIN = 60;
    localparam logic [15:0] RECIP_MUL   = 16'd34953;
    localparam int          RECIP_SHIFT = 21;

endpackage

@@ hw/rtl/kr_cell.sv @@
// One cell of the record chain: holds a single entry and its key match flag.
// Loads, edits or takes its upper neighbor's entry as the controller commands.
// Depends on kr_pkg.
`timescale 1ns / 1ps

module kr_cell #(
    parameter int KEY_BITS  = 16,
    parameter int TEXT_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kr_pkg::kr_cell_ctl_t ctl,
    input  logic [KEY_BITS-1:0]  new_key,
    input  logic [15:0]          new_dur,
    input  logic [TEXT_BITS-1:0] new_title,
    input  logic [TEXT_BITS-1:0] new_artist,
    input  logic [TEXT_BITS-1:0] new_genre,
    input  logic [KEY_BITS-1:0]  nxt_key,
    input  logic [15:0]          nxt_dur,
    input  logic [TEXT_BITS-1:0] nxt_title,
    input  logic [TEXT_BITS-1:0] nxt_artist,
    input  logic [TEXT_BITS-1:0] nxt_genre,
    output logic [KEY_BITS-1:0]  key,
    output logic [15:0]          dur,
    output logic [TEXT_BITS-1:0] title,
    output logic [TEXT_BITS-1:0] artist,
    output logic [TEXT_BITS-1:0] genre,
    output logic                 match
);
    import kr_pkg::*;

    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [15:0]          dur_reg, dur_next;
    logic [TEXT_BITS-1:0] title_reg, title_next;
    logic [TEXT_BITS-1:0] artist_reg, artist_next;
    logic [TEXT_BITS-1:0] genre_reg, genre_next;
    logic                 match_reg, match_next;

    // Next entry contents and match flag from the broadcast command.
    always_comb
    begin
        key_next    = key_reg;
        dur_next    = dur_reg;
        title_next  = title_reg;
        artist_next = artist_reg;
        genre_next  = genre_reg;
        match_next  = match_reg;
        unique case (ctl.op)
            CELL_CMP:
            begin
                match_next = ctl.live && (key_reg == new_key);
            end
            CELL_LOAD:
            begin
                if (ctl.sel)
                begin
                    key_next    = new_key;
                    dur_next    = new_dur;
                    title_next  = new_title;
                    artist_next = new_artist;
                    genre_next  = new_genre;
                end
            end
            CELL_EDIT:
            begin
                if (ctl.sel)
                begin
                    case (ctl.edit)
                        ED_TITLE:    title_next  = new_title;
                        ED_ARTIST:   artist_next = new_artist;
                        ED_DURATION: dur_next    = new_dur;
                        ED_GENRE:    genre_next  = new_genre;
                        default:     ;
                    endcase
                end
            end
            CELL_SHIFT:
            begin
                if (ctl.above)
                begin
                    key_next    = nxt_key;
                    dur_next    = nxt_dur;
                    title_next  = nxt_title;
                    artist_next = nxt_artist;
                    genre_next  = nxt_genre;
                end
            end
            default: ;
        endcase
    end

    // Match flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        dur_reg    <= dur_next;
        title_reg  <= title_next;
        artist_reg <= artist_next;
        genre_reg  <= genre_next;
    end

    assign key    = key_reg;
    assign dur    = dur_reg;
    assign title  = title_reg;
    assign artist = artist_reg;
    assign genre  = genre_reg;
    assign match  = match_reg;

endmodule

@@ hw/rtl/kr_fmt.sv @@
// Result formatter: splits the duration into minutes and seconds over two stages.
// Minutes come from a reciprocal multiply; seconds from a shift-and-subtract.
// Depends on kr_pkg.
`timescale 1ns / 1ps

module kr_fmt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  kr_pkg::kr_res_t req,
    output logic            done,
    output kr_pkg::kr_res_t result
);
    import kr_pkg::*;

    logic        v1_reg;
    kr_res_t     res1_reg;
    logic [31:0] prod1_reg;
    logic        done_reg;
    kr_res_t     result_reg;

    logic [10:0] minutes;
    logic [16:0] min_x60;
    logic [15:0] secs_wide;
    kr_res_t     result_next;

    // Minutes and remainder from the registered product.
    always_comb
    begin
        minutes     = prod1_reg[RECIP_SHIFT +: 11];
        min_x60     = {minutes, 6'b0} - {4'b0, minutes, 2'b0};
        secs_wide   = res1_reg.duration_out - min_x60[15:0];
        result_next = res1_reg;
        result_next.minutes_out = minutes;
        result_next.seconds_out = secs_wide[5:0];
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req_valid;
            done_reg <= v1_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        res1_reg   <= req;
        prod1_reg  <= 32'(req.duration_out) * 32'(RECIP_MUL);
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.seconds_out < 6'd60))
        else $error("seconds out of range");

    a_split_exact: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((16'(result.minutes_out) * 16'd60 + 16'(result.seconds_out))
                  == result.duration_out))
        else $error("minutes and seconds do not rebuild the duration");
`endif

endmodule

@@ hw/rtl/kr_ctrl.sv @@
// Controller for the keyed record table: sequences compare, find and act steps.
// Drives the cell chain commands and builds the raw result for the formatter.
// Depends on kr_pkg.
`timescale 1ns / 1ps

module kr_ctrl #(
    parameter int   ENTRIES   = 32,
    parameter int   KEY_BITS  = 16,
    parameter int   TEXT_BITS = 64,
    localparam int  IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int  CNT_W     = $clog2(ENTRIES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  kr_pkg::kr_req_t      req,
    output logic                 busy,
    input  logic [ENTRIES-1:0]   hits,
    input  logic [KEY_BITS-1:0]  rd_key,
    input  logic [15:0]          rd_dur,
    input  logic [TEXT_BITS-1:0] rd_title,
    input  logic [TEXT_BITS-1:0] rd_artist,
    input  logic [TEXT_BITS-1:0] rd_genre,
    output kr_pkg::kr_cmd_t      cmd,
    output logic [IDX_W-1:0]     tgt,
    output logic [CNT_W-1:0]     count,
    output logic [IDX_W-1:0]     rd_idx,
    output logic [KEY_BITS-1:0]  new_key,
    output logic [15:0]          new_dur,
    output logic [TEXT_BITS-1:0] new_title,
    output logic [TEXT_BITS-1:0] new_artist,
    output logic [TEXT_BITS-1:0] new_genre,
    output logic                 res_valid,
    output kr_pkg::kr_res_t      res
);
    import kr_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic                 found_reg, found_next;

    logic [2:0]           action_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [15:0]          dur_reg;
    logic [TEXT_BITS-1:0] title_reg;
    logic [TEXT_BITS-1:0] artist_reg;
    logic [TEXT_BITS-1:0] genre_reg;
    logic [2:0]           edit_reg;

    logic                 accept;
    logic                 list_last;
    logic [IDX_W-1:0]     hit_pos;
    logic [KEY_BITS+15:0] key_in_wide;
    logic [KEY_BITS+15:0] rd_key_wide;
    logic [KEY_BITS+15:0] new_key_wide;
    logic [TEXT_BITS+63:0] rd_title_wide, rd_artist_wide, rd_genre_wide;
    logic [TEXT_BITS+63:0] new_title_wide, new_artist_wide, new_genre_wide;
    logic [IDX_W+4:0]     rd_slot_wide;
    logic [IDX_W+4:0]     ins_slot_wide;
    logic [CNT_W+5:0]     fill_wide;
    logic [CNT_W+5:0]     fill_inc_wide;
    logic [CNT_W+5:0]     fill_dec_wide;
    kr_res_t              rd_res;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign list_last = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));

    // First matching entry over the registered match flags.
    always_comb
    begin
        hit_pos = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                hit_pos = IDX_W'(i);
            end
        end
    end

    // Width adaption between stored entries and the fixed result fields.
    assign key_in_wide     = {KEY_BITS'(0), req.key};
    assign rd_key_wide     = {16'b0, rd_key};
    assign new_key_wide    = {16'b0, key_reg};
    assign rd_title_wide   = {64'b0, rd_title};
    assign rd_artist_wide  = {64'b0, rd_artist};
    assign rd_genre_wide   = {64'b0, rd_genre};
    assign new_title_wide  = {64'b0, title_reg};
    assign new_artist_wide = {64'b0, artist_reg};
    assign new_genre_wide  = {64'b0, genre_reg};
    assign rd_slot_wide    = {5'b0, rd_idx};
    assign ins_slot_wide   = {5'b0, count_reg[IDX_W-1:0]};
    assign fill_wide       = {6'b0, count_reg};
    assign fill_inc_wide   = {6'b0, count_reg + CNT_W'(1)};
    assign fill_dec_wide   = {6'b0, count_reg - CNT_W'(1)};

    // Result describing the entry on the read port.
    always_comb
    begin
        rd_res              = '0;
        rd_res.status       = ST_OK;
        rd_res.slot         = rd_slot_wide[4:0];
        rd_res.key_out      = rd_key_wide[15:0];
        rd_res.duration_out = rd_dur;
        rd_res.title_out    = rd_title_wide[63:0];
        rd_res.artist_out   = rd_artist_wide[63:0];
        rd_res.genre_out    = rd_genre_wide[63:0];
        rd_res.fill_count   = fill_wide[5:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.action == ACT_LIST)
                    begin
                        state_next = (count_reg == '0) ? S_IDLE : S_LIST;
                    end
                    else if (req.action == ACT_INSERT || req.action == ACT_LOOKUP ||
                             req.action == ACT_UPDATE || req.action == ACT_DELETE)
                    begin
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:   state_next = S_FIND;
            S_FIND:  state_next = S_ACT;
            S_ACT:   state_next = S_IDLE;
            S_LIST:
            begin
                if (list_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs, chain commands and counter updates.
    always_comb
    begin
        cmd.op     = CELL_HOLD;
        cmd.edit   = edit_reg;
        tgt        = pos_reg;
        rd_idx     = pos_reg;
        res_valid  = 1'b0;
        res        = rd_res;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        found_next = found_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (start && req.action == ACT_LIST && count_reg == '0)
                begin
                    res_valid      = 1'b1;
                    res            = '0;
                    res.status     = ST_EMPTY;
                    res.fill_count = fill_wide[5:0];
                    res.last       = 1'b1;
                end
            end
            S_CMP:
            begin
                cmd.op = CELL_CMP;
            end
            S_FIND:
            begin
                pos_next   = hit_pos;
                found_next = |hits;
            end
            S_ACT:
            begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                case (action_reg)
                    ACT_INSERT:
                    begin
                        if (count_reg == CNT_W'(ENTRIES))
                        begin
                            res            = '0;
                            res.status     = ST_FULL;
                            res.fill_count = fill_wide[5:0];
                            res.last       = 1'b1;
                        end
                        else if (found_reg)
                        begin
                            res            = '0;
                            res.status     = ST_DUP;
                            res.fill_count = fill_wide[5:0];
                            res.last       = 1'b1;
                        end
                        else
                        begin
                            cmd.op           = CELL_LOAD;
                            tgt              = count_reg[IDX_W-1:0];
                            count_next       = count_reg + CNT_W'(1);
                            res.status       = ST_OK;
                            res.slot         = ins_slot_wide[4:0];
                            res.key_out      = new_key_wide[15:0];
                            res.duration_out = dur_reg;
                            res.title_out    = new_title_wide[63:0];
                            res.artist_out   = new_artist_wide[63:0];
                            res.genre_out    = new_genre_wide[63:0];
                            res.fill_count   = fill_inc_wide[5:0];
                        end
                    end
                    ACT_LOOKUP, ACT_UPDATE, ACT_DELETE:
                    begin
                        if (!found_reg)
                        begin
                            res            = '0;
                            res.status     = ST_NOT_FOUND;
                            res.fill_count = fill_wide[5:0];
                            res.last       = 1'b1;
                        end
                        else if (action_reg == ACT_UPDATE)
                        begin
                            // The result shows the entry as it stands after the edit.
                            cmd.op = CELL_EDIT;
                            case (edit_reg)
                                ED_TITLE:    res.title_out    = new_title_wide[63:0];
                                ED_ARTIST:   res.artist_out   = new_artist_wide[63:0];
                                ED_DURATION: res.duration_out = dur_reg;
                                ED_GENRE:    res.genre_out    = new_genre_wide[63:0];
                                ED_CANCEL:   res.status       = ST_CANCEL;
                                default:     res.status       = ST_INVALID;
                            endcase
                        end
                        else if (action_reg == ACT_DELETE)
                        begin
                            // Report the old entry, then close the gap.
                            cmd.op         = CELL_SHIFT;
                            count_next     = count_reg - CNT_W'(1);
                            res.fill_count = fill_dec_wide[5:0];
                        end
                    end
                    default:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
            S_LIST:
            begin
                rd_idx    = idx_reg;
                res_valid = 1'b1;
                res.last  = list_last;
                idx_next  = idx_reg + IDX_W'(1);
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            found_reg <= found_next;
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= req.action;
            key_reg    <= key_in_wide[KEY_BITS-1:0];
            dur_reg    <= req.duration_in;
            title_reg  <= req.title_in[TEXT_BITS-1:0];
            artist_reg <= req.artist_in[TEXT_BITS-1:0];
            genre_reg  <= req.genre_in[TEXT_BITS-1:0];
            edit_reg   <= req.edit_field;
        end
    end

    assign count      = count_reg;
    assign new_key    = key_reg;
    assign new_dur    = dur_reg;
    assign new_title  = title_reg;
    assign new_artist = artist_reg;
    assign new_genre  = genre_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("fill count above table size");

    a_list_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("list index past the last entry");
`endif

endmodule

@@ hw/rtl/keyed_record_table.sv @@
// Keyed record table: a packed chain of record cells with broadcast key compare.
// Lookup, insert, update, delete: busy in the compare, find and act states, taking no new
// request until idle; the result strobe follows act through the two format stages. List:
// one result per entry per cycle, busy to the last entry; an empty list gives ST_EMPTY,
// never busy; unused codes are ignored. The receiver cannot stall; reset empties the table.
`timescale 1ns / 1ps

module keyed_record_table #(
    parameter int ENTRIES   = 32,
    parameter int KEY_BITS  = 16,
    parameter int TEXT_BITS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  kr_pkg::kr_req_t request,
    output logic            busy,
    output logic            done,
    output kr_pkg::kr_res_t result
);
    import kr_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    kr_cmd_t              cmd;
    logic [IDX_W-1:0]     tgt;
    logic [CNT_W-1:0]     count;
    logic [IDX_W-1:0]     rd_idx;
    logic [KEY_BITS-1:0]  new_key;
    logic [15:0]          new_dur;
    logic [TEXT_BITS-1:0] new_title, new_artist, new_genre;
    logic [ENTRIES-1:0]   hits;
    logic                 res_valid;
    kr_res_t              res;

    logic [KEY_BITS-1:0]  cell_key    [ENTRIES];
    logic [15:0]          cell_dur    [ENTRIES];
    logic [TEXT_BITS-1:0] cell_title  [ENTRIES];
    logic [TEXT_BITS-1:0] cell_artist [ENTRIES];
    logic [TEXT_BITS-1:0] cell_genre  [ENTRIES];
    logic [KEY_BITS-1:0]  nxt_key     [ENTRIES];
    logic [15:0]          nxt_dur     [ENTRIES];
    logic [TEXT_BITS-1:0] nxt_title   [ENTRIES];
    logic [TEXT_BITS-1:0] nxt_artist  [ENTRIES];
    logic [TEXT_BITS-1:0] nxt_genre   [ENTRIES];
    kr_cell_ctl_t         cell_ctl    [ENTRIES];

    // Cell chain; each cell at or after the target takes its upper neighbor's entry on a shift.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        assign cell_ctl[i].op    = cmd.op;
        assign cell_ctl[i].edit  = cmd.edit;
        assign cell_ctl[i].sel   = (tgt == IDX_W'(i));
        assign cell_ctl[i].above = (tgt <= IDX_W'(i));
        assign cell_ctl[i].live  = (CNT_W'(i) < count);

        if (i == ENTRIES - 1)
        begin : g_top
            assign nxt_key[i]    = cell_key[i];
            assign nxt_dur[i]    = cell_dur[i];
            assign nxt_title[i]  = cell_title[i];
            assign nxt_artist[i] = cell_artist[i];
            assign nxt_genre[i]  = cell_genre[i];
        end
        else
        begin : g_link
            assign nxt_key[i]    = cell_key[i+1];
            assign nxt_dur[i]    = cell_dur[i+1];
            assign nxt_title[i]  = cell_title[i+1];
            assign nxt_artist[i] = cell_artist[i+1];
            assign nxt_genre[i]  = cell_genre[i+1];
        end

        kr_cell #(
            .KEY_BITS  (KEY_BITS),
            .TEXT_BITS (TEXT_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl[i]),
            .new_key    (new_key),
            .new_dur    (new_dur),
            .new_title  (new_title),
            .new_artist (new_artist),
            .new_genre  (new_genre),
            .nxt_key    (nxt_key[i]),
            .nxt_dur    (nxt_dur[i]),
            .nxt_title  (nxt_title[i]),
            .nxt_artist (nxt_artist[i]),
            .nxt_genre  (nxt_genre[i]),
            .key        (cell_key[i]),
            .dur        (cell_dur[i]),
            .title      (cell_title[i]),
            .artist     (cell_artist[i]),
            .genre      (cell_genre[i]),
            .match      (hits[i])
        );
    end

    // Sequencer.
    kr_ctrl #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .TEXT_BITS (TEXT_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (request),
        .busy       (busy),
        .hits       (hits),
        .rd_key     (cell_key[rd_idx]),
        .rd_dur     (cell_dur[rd_idx]),
        .rd_title   (cell_title[rd_idx]),
        .rd_artist  (cell_artist[rd_idx]),
        .rd_genre   (cell_genre[rd_idx]),
        .cmd        (cmd),
        .tgt        (tgt),
        .count      (count),
        .rd_idx     (rd_idx),
        .new_key    (new_key),
        .new_dur    (new_dur),
        .new_title  (new_title),
        .new_artist (new_artist),
        .new_genre  (new_genre),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Duration split and output registers.
    kr_fmt u_fmt (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (res_valid),
        .req       (res),
        .done      (done),
        .result    (result)
    );

endmodule
